// ===== rtl/core/ertc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ertc_pkg
// Shared types and constants of the EWMA RTT table with centdian score.
// ----------------------------------------------------------------------------
package ertc_pkg;

	localparam int WEIGHT_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 2'd1;

	localparam logic [WEIGHT_W-1:0] SMOOTHING_RST = 16'd57344;
	localparam logic [WEIGHT_W-1:0] CENTER_RST    = 16'd32768;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic [WEIGHT_W:0] ONE_Q16 = 17'h10000;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic en;   // take a product this cycle
		logic clr;  // product starts a new sum
	} mac_op_t;

endpackage
`default_nettype wire

// ===== rtl/core/ertc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ertc_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface ertc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  peer_id;
	logic [31:0] rtt_sample;
	modport source (output valid, req_type, peer_id, rtt_sample, input ready);
	modport sink   (input valid, req_type, peer_id, rtt_sample, output ready);
endinterface

interface ertc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] smoothed_rtt;
	logic [31:0] score;
	logic [8:0]  nonzero_count;
	logic        no_entries;
	modport source (output valid, smoothed_rtt, score, nonzero_count, no_entries,
		input ready);
	modport sink   (input valid, smoothed_rtt, score, nonzero_count, no_entries,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ertc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ertc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ertc_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/ertc_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ertc_mac
// Shared Q1.16 weight times RTT multiplier with accumulator; the product is registered before it is accumulated.
// ----------------------------------------------------------------------------
module ertc_mac #(
	parameter int RTT_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ertc_pkg::mac_op_t      op,
	input  wire logic [16:0]            wgt,
	input  wire logic [RTT_BITS-1:0]    val,
	output logic      [RTT_BITS+16:0]   acc_q
);

	ertc_pkg::mac_op_t      op_s1;
	logic [RTT_BITS+16:0]   prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= (RTT_BITS+17)'(wgt) * (RTT_BITS+17)'(val);
		if (op_s1.en) begin
			acc_q <= (op_s1.clr ? '0 : acc_q) + prod_s1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ewma_rtt_table_centdian_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ewma_rtt_table_centdian_core
// Per-peer EWMA RTT table; queries return lambda*max + (1-lambda)*median.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch takes one transaction at a time. req_type 0 folds rtt_sample into
//    peer peer_id; req_type 1 scores the whole table.
//  - rsp_ch returns exactly one transaction per request. It is held until
//    taken; a stalled receiver stalls the request side (ready stays low).
//  - cfg_we/cfg_index/cfg_data write alpha (index 0) and lambda (index 1)
//    at any edge; write them only while idle.
//  - Update: ST_UPD_M1 and ST_UPD_M2 (two products on the shared multiplier),
//    ST_WAIT (accumulate), ST_FIN (write back), then the result in ST_OUT.
//    Out-of-range peer: result valid in the cycle after accept.
//  - Query: one pass over the table for max and count, then one pass per
//    distinct nonzero value up to the median, then ST_MED, ST_SC_M1,
//    ST_SC_M2, ST_WAIT and ST_FIN for the blend. Each pass reads the whole
//    table through the single RAM read port.
//  - Reset: a clearing pass writes every RAM row invalid, during which no
//    request is accepted. Config registers go to alpha=0.875, lambda=0.5.
// ----------------------------------------------------------------------------
module ewma_rtt_table_centdian_core #(
	parameter int MAX_PEERS = 256,
	parameter int RTT_BITS  = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ertc_req_if.sink                               req_ch,
	ertc_rsp_if.source                             rsp_ch,
	input  wire logic                              cfg_we,
	input  wire logic [ertc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ertc_pkg::CFG_DAT_W-1:0]    cfg_data
);

	localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
	localparam int CW = $clog2(MAX_PEERS + 1);
	localparam int SW = (RTT_BITS > 32) ? RTT_BITS : 32;
	localparam int DW = RTT_BITS + 1;   // valid bit on top of the RTT

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_UPD_M1, ST_UPD_M2, ST_SCAN, ST_SCAN_END,
		ST_MED, ST_SC_M1, ST_SC_M2, ST_WAIT, ST_FIN, ST_OUT
	} state_t;

	state_t                 state_q;
	logic [AW:0]            ci_q;        // clear / scan address counter
	logic                   rdv_s1;      // RAM read data holds a scan row
	logic                   pass0_q;     // max/count pass
	logic                   query_q;
	logic [AW-1:0]          peer_q;
	logic [RTT_BITS-1:0]    sample_q;
	logic [RTT_BITS-1:0]    maxv_q;
	logic [CW-1:0]          n_q;
	logic [RTT_BITS-1:0]    cur_q, m_q, vlo_q, vhi_q, med_q;
	logic                   mfound_q, lofound_q;
	logic [CW-1:0]          cnt_q, cum_q, lo_rank_q, hi_rank_q;
	logic [15:0]            alpha_q, lambda_q;

	logic [31:0]            res_rtt_q, res_score_q;
	logic [8:0]             res_cnt_q;
	logic                   res_none_q;

	// RAM
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [DW-1:0]          ram_wdata, ram_rdata;

	// shared MAC
	ertc_pkg::mac_op_t      mac_op;
	logic [16:0]            mac_wgt;
	logic [RTT_BITS-1:0]    mac_val;
	logic [RTT_BITS+16:0]   mac_acc;

	// datapath helpers
	logic                   in_acc;
	logic                   peer_bad;
	logic [AW-1:0]          in_addr;
	logic [SW-1:0]          smp_w, smp_max;
	logic [RTT_BITS-1:0]    smp_clamped;
	logic                   ev;
	logic [RTT_BITS-1:0]    vv;
	logic [CW-1:0]          newcum;
	logic [RTT_BITS-1:0]    acc_res;
	logic [SW-1:0]          acc_res_w;
	logic [31:0]            acc_res32;
	logic [31:0]            n_w;
	logic [RTT_BITS:0]      med_sum;

	ertc_ram #(.WIDTH(DW), .DEPTH(MAX_PEERS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ertc_mac #(.RTT_BITS(RTT_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.wgt    (mac_wgt),
		.val    (mac_val),
		.acc_q  (mac_acc)
	);

	assign req_ch.ready = (state_q == ST_IDLE);
	assign in_acc       = req_ch.valid && req_ch.ready;
	assign peer_bad     = ({24'd0, req_ch.peer_id} >= 32'(MAX_PEERS));
	assign in_addr      = AW'({24'd0, req_ch.peer_id});

	// samples wider than the table are clamped
	assign smp_w        = SW'(req_ch.rtt_sample);
	assign smp_max      = SW'({RTT_BITS{1'b1}});
	assign smp_clamped  = RTT_BITS'((smp_w > smp_max) ? smp_max : smp_w);

	assign ev = ram_rdata[RTT_BITS];
	assign vv = ram_rdata[RTT_BITS-1:0];

	assign newcum    = cum_q + cnt_q;
	assign acc_res   = mac_acc[16 +: RTT_BITS];
	assign acc_res_w = SW'(acc_res);
	assign acc_res32 = (acc_res_w > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : acc_res_w[31:0];
	assign n_w       = 32'(n_q);
	assign med_sum   = {1'b0, vlo_q} + {1'b0, vhi_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ci_q[AW-1:0];
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_FIN && !query_q) begin
			ram_we    = 1'b1;
			ram_waddr = peer_q;
			ram_wdata = {1'b1, acc_res};
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: ram_raddr = in_addr;
			ST_SCAN: ram_raddr = ci_q[AW-1:0];
			default: ram_raddr = peer_q;
		endcase
	end

	always_comb begin
		mac_op  = '0;
		mac_wgt = '0;
		mac_val = '0;
		unique case (state_q)
			ST_UPD_M1: begin
				mac_op  = '{en: 1'b1, clr: 1'b1};
				mac_wgt = {1'b0, alpha_q};
				mac_val = ev ? vv : '0;
			end
			ST_UPD_M2: begin
				mac_op  = '{en: 1'b1, clr: 1'b0};
				mac_wgt = ertc_pkg::ONE_Q16 - {1'b0, alpha_q};
				mac_val = sample_q;
			end
			ST_SC_M1: begin
				mac_op  = '{en: 1'b1, clr: 1'b1};
				mac_wgt = {1'b0, lambda_q};
				mac_val = maxv_q;
			end
			ST_SC_M2: begin
				mac_op  = '{en: 1'b1, clr: 1'b0};
				mac_wgt = ertc_pkg::ONE_Q16 - {1'b0, lambda_q};
				mac_val = med_q;
			end
			default: ;
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ertc_pkg::SMOOTHING_RST;
			lambda_q <= ertc_pkg::CENTER_RST;
		end else if (cfg_we) begin
			if (cfg_index == ertc_pkg::CFG_SMOOTHING) alpha_q <= cfg_data;
			if (cfg_index == ertc_pkg::CFG_CENTER)    lambda_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ci_q    <= '0;
			rdv_s1  <= 1'b0;
			pass0_q <= 1'b0;
			query_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					ci_q <= ci_q + 1'b1;
					if (ci_q == (AW+1)'(MAX_PEERS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						res_rtt_q   <= '0;
						res_score_q <= '0;
						res_cnt_q   <= '0;
						res_none_q  <= 1'b0;
						query_q     <= (req_ch.req_type == ertc_pkg::REQ_QUERY);
						peer_q      <= in_addr;
						sample_q    <= smp_clamped;
						if (req_ch.req_type == ertc_pkg::REQ_QUERY) begin
							pass0_q <= 1'b1;
							maxv_q  <= '0;
							n_q     <= '0;
							ci_q    <= '0;
							state_q <= ST_SCAN;
						end else if (peer_bad) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_UPD_M1;
						end
					end
				end
				ST_UPD_M1: state_q <= ST_UPD_M2;
				ST_UPD_M2: state_q <= ST_WAIT;
				ST_SCAN: begin
					if (ci_q != (AW+1)'(MAX_PEERS)) begin
						ci_q   <= ci_q + 1'b1;
						rdv_s1 <= 1'b1;
					end else begin
						rdv_s1 <= 1'b0;
						if (!rdv_s1) state_q <= ST_SCAN_END;
					end
					if (rdv_s1 && ev) begin
						if (pass0_q) begin
							if (vv > maxv_q) maxv_q <= vv;
							if (vv != '0)    n_q <= n_q + 1'b1;
						end else if (vv > cur_q) begin
							if (!mfound_q || vv < m_q) begin
								m_q      <= vv;
								cnt_q    <= CW'(1);
								mfound_q <= 1'b1;
							end else if (vv == m_q) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
					end
				end
				ST_SCAN_END: begin
					ci_q     <= '0;
					mfound_q <= 1'b0;
					if (pass0_q) begin
						pass0_q   <= 1'b0;
						lo_rank_q <= (n_q - 1'b1) >> 1;
						hi_rank_q <= n_q >> 1;
						cur_q     <= '0;
						cum_q     <= '0;
						lofound_q <= 1'b0;
						if (n_q == '0) begin
							res_none_q <= 1'b1;
							state_q    <= ST_OUT;
						end else begin
							state_q <= ST_SCAN;
						end
					end else begin
						if (!lofound_q && lo_rank_q < newcum) begin
							vlo_q     <= m_q;
							lofound_q <= 1'b1;
						end
						if (hi_rank_q < newcum) begin
							vhi_q   <= m_q;
							state_q <= ST_MED;
						end else begin
							cur_q   <= m_q;
							cum_q   <= newcum;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_MED: begin
					med_q   <= med_sum[RTT_BITS:1];
					state_q <= ST_SC_M1;
				end
				ST_SC_M1: state_q <= ST_SC_M2;
				ST_SC_M2: state_q <= ST_WAIT;
				ST_WAIT:  state_q <= ST_FIN;
				ST_FIN: begin
					if (query_q) begin
						res_score_q <= acc_res32;
						res_cnt_q   <= (n_w > 32'd511) ? 9'd511 : n_w[8:0];
					end else begin
						res_rtt_q <= acc_res32;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp_ch.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_ch.valid         = (state_q == ST_OUT);
	assign rsp_ch.smoothed_rtt  = res_rtt_q;
	assign rsp_ch.score         = res_score_q;
	assign rsp_ch.nonzero_count = res_cnt_q;
	assign rsp_ch.no_entries    = res_none_q;

	// a request is never taken while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req_ch.ready |-> !rsp_ch.valid)
		else $error("request accepted while result pending");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && rsp_ch.no_entries |->
			rsp_ch.score == 32'd0 && rsp_ch.nonzero_count == 9'd0 &&
			rsp_ch.smoothed_rtt == 32'd0)
		else $error("empty query with nonzero fields");

	a_update_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && rsp_ch.smoothed_rtt != 32'd0 |->
			rsp_ch.score == 32'd0 && rsp_ch.nonzero_count == 9'd0)
		else $error("update result carries query fields");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ch.valid && req_ch.ready |=> !req_ch.ready)
		else $error("sequencer stayed idle after accept");

endmodule
`default_nettype wire
